>>> design/swept_tone_bridge_pulse_generator_core_macros.svh
// Assertion macros shared by the swept tone bridge pulse generator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SWEPT_TONE_BRIDGE_PULSE_GENERATOR_CORE_MACROS_SVH
`define SWEPT_TONE_BRIDGE_PULSE_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/stbpg_pkg.sv
// Shared types and constants for the swept tone bridge pulse generator.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package stbpg_pkg;

  localparam int FreqBits = 12;
  localparam int FreqW    = 12;
  localparam int DurW     = 16;
  localparam int PctW     = 7;
  localparam int MsW      = 8;
  localparam int PatW     = 4;
  localparam int LenW     = 16;
  localparam int DivNumW  = 28;
  localparam int DivDenW  = 21;

  // Division by 100 as floor(x * Recip100 / 2**RecipShift), exact for x below 2**30.
  localparam int RecipW     = 27;
  localparam int RecipShift = 33;
  localparam int ProdW      = DivNumW + RecipW;
  localparam logic [RecipW-1:0] Recip100 = 27'd85899346;

  localparam logic [PatW-1:0] PatHighOn = 4'h5;
  localparam logic [PatW-1:0] PatLowOn  = 4'h9;
  localparam logic [PatW-1:0] PatOff    = 4'h1;

  localparam logic [PctW-1:0] PctFull      = 7'd100;
  localparam logic [PctW-1:0] RatioReset   = 7'd85;
  localparam logic [MsW-1:0]  SubstepReset = 8'd20;

  localparam logic CfgRatio   = 1'b0;
  localparam logic CfgSubstep = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [FreqW-1:0] start_freq;
    logic [FreqW-1:0] end_freq;
    logic [DurW-1:0]  duration;
    logic [PctW-1:0]  duty;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivNumW-1:0] quotient;
  } div_rsp_t;

  function automatic logic [PatW-1:0] phase_pattern(input logic [1:0] idx);
    logic [PatW-1:0] pat;
    case (idx)
      2'd0:    pat = PatHighOn;
      2'd2:    pat = PatLowOn;
      default: pat = PatOff;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

>>> design/swept_tone_bridge_pulse_generator_core.sv
// Channel   Dir  Transfer carries
// s_axis    in   tuser cmd; tdata start_freq, end_freq, duration, duty
// m_axis    out  tdata drive_pattern; tuser busy; tlast segment end
// cfg       in   register index and data, one write per enabled cycle
// A tick that opens a sub-step runs four divisions on the shared one-bit-per-cycle
// divider and four scalings by 1/100.
// A two-entry input queue and the output register let both sides stall freely.
// Reset is asynchronous and leaves the block idle with registers at defaults.
// Top level of the swept tone bridge pulse generator; depends on stbpg_pkg,
// stbpg_front, stbpg_div and stbpg_seq.
`default_nettype none

module swept_tone_bridge_pulse_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // start_freq, end_freq, duration_ms, duty_percent
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // drive_pattern
  output logic        m_axis_tuser,  // busy_res
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import stbpg_pkg::*;

  logic [PctW-1:0] ratio_q;
  logic [MsW-1:0]  substep_q;
  item_t           item;
  logic            item_valid, pop;
  div_req_t        div_req;
  div_rsp_t        div_rsp;
  logic [PatW-1:0] pat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q   <= RatioReset;
      substep_q <= SubstepReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRatio:   ratio_q   <= cfg_data_i[PctW-1:0];
        CfgSubstep: substep_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  stbpg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .pop_i         (pop)
  );

  stbpg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  stbpg_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .ratio_i      (ratio_q),
    .substep_ms_i (substep_q),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_pat_o    (pat),
    .out_busy_o   (m_axis_tuser),
    .out_done_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, pat};

endmodule

`default_nettype wire

>>> design/stbpg_front.sv
// Input side: accepts stream transfers, saturates the duty and queues items.
// Depends on stbpg_pkg.
`default_nettype none

module stbpg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // start_freq, end_freq, duration, duty
  input  logic                s_axis_tuser,  // cmd
  output logic                item_valid_o,
  output stbpg_pkg::item_t    item_o,
  input  logic                pop_i
);
  import stbpg_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       wr, rd;
  item_t      in_item;
  logic [PctW-1:0] duty_raw;

  assign duty_raw = s_axis_tdata[46:40];
  always_comb begin
    in_item.cmd        = s_axis_tuser;
    in_item.start_freq = s_axis_tdata[11:0];
    in_item.end_freq   = s_axis_tdata[23:12];
    in_item.duration   = s_axis_tdata[39:24];
    in_item.duty       = (duty_raw > PctFull) ? PctFull : duty_raw;
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign wr = s_axis_tvalid && s_axis_tready;
  assign rd = pop_i && (cnt_q != 2'd0);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

`default_nettype wire

>>> design/stbpg_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on stbpg_pkg.
`default_nettype none

module stbpg_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stbpg_pkg::div_req_t req_i,
  output stbpg_pkg::div_rsp_t rsp_o
);
  import stbpg_pkg::*;

  localparam logic [4:0] Steps = 5'(DivNumW);

  logic [DivNumW-1:0] quot_q, quot_d;
  logic [DivDenW-1:0] rem_q, rem_d, den_q, den_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DivDenW:0]   shifted, trial;

  assign shifted = {rem_q, quot_q[DivNumW-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = Steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivDenW]) begin
        rem_d  = trial[DivDenW-1:0];
        quot_d = {quot_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_d  = shifted[DivDenW-1:0];
        quot_d = {quot_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 5'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule

`default_nettype wire

>>> design/stbpg_seq.sv
// Back end: sweep sequencer, sub-step setup through the shared divider, output register.
// Depends on stbpg_pkg and the assertion macro header.
`default_nettype none
`include "swept_tone_bridge_pulse_generator_core_macros.svh"

module stbpg_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  stbpg_pkg::item_t       item_i,
  output logic                   pop_o,
  input  logic [6:0]             ratio_i,
  input  logic [7:0]             substep_ms_i,
  output stbpg_pkg::div_req_t    div_req_o,
  input  stbpg_pkg::div_rsp_t    div_rsp_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [3:0]             out_pat_o,
  output logic                   out_busy_o,
  output logic                   out_done_o
);
  import stbpg_pkg::*;

  localparam logic [FreqW-1:0] FreqMask = FreqW'((32'd1 << FreqBits) - 32'd1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_TICK  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  typedef enum logic [3:0] {
    OP_TOT, OP_Q, OP_TH, OP_TL, OP_N, OP_U0, OP_U1, OP_U2, OP_U3
  } op_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [DurW-1:0]  dur_q, dur_d;
  logic [PctW-1:0]  duty_q, duty_d;
  logic [FreqW-1:0] start_q, start_d, end_q, end_d, f_q, f_d;
  logic [15:0]      total_q, total_d, index_q, index_d, periods_q, periods_d;
  logic [1:0]       pidx_q, pidx_d;
  logic [LenW-1:0]  ticks_q, ticks_d;
  logic [LenW-1:0]  len_q [4];
  logic [LenW-1:0]  len_d [4];
  logic             active_q, active_d, neg_q, neg_d;
  logic [19:0]      th_q, th_d, tl_q, tl_d;
  logic [PatW-1:0]  res_pat_q, res_pat_d;
  logic             res_busy_q, res_busy_d, res_done_q, res_done_d;
  logic             ov_q, ov_d;
  logic [PatW-1:0]  opat_q, opat_d;
  logic             obusy_q, obusy_d, odone_q, odone_d;
  logic [DivNumW-1:0] prod_q, prod_d;

  logic [PctW-1:0]    ratio_sat, ratio_inv, duty_inv;
  logic signed [12:0] diff_s;
  logic [11:0]        diff_mag;
  logic [20:0]        sum;
  logic [DivNumW-1:0] quot;
  logic [ProdW-1:0]   recip_prod;
  logic               const_div;
  logic signed [13:0] q_s, fs;
  logic [LenW-1:0]    len_new, n_sat;
  logic [LenW-1:0]    t1;
  logic [3:0]         nz, nz_post;
  logic [2:0]         sk_next, sk0, sk_post;
  logic [15:0]        idx_inc, periods_m1;
  logic               fin, empty, end_sub;

  function automatic logic [2:0] seek(input logic [3:0] nzv, input logic [2:0] from);
    logic [2:0] res;
    res = 3'b000;
    for (int j = 3; j >= 0; j--) begin
      if ((3'(j) >= from) && nzv[j]) res = {1'b1, 2'(j)};
    end
    return res;
  endfunction

  assign const_div  = (op_q == OP_U0) || (op_q == OP_U1) || (op_q == OP_U2) ||
                      (op_q == OP_U3);
  assign recip_prod = ProdW'(prod_q) * ProdW'(Recip100);
  assign ratio_sat  = (ratio_i > PctFull) ? PctFull : ratio_i;
  assign ratio_inv  = PctFull - ratio_sat;
  assign duty_inv   = PctFull - duty_q;
  assign diff_s     = $signed({1'b0, end_q}) - $signed({1'b0, start_q});
  assign diff_mag   = diff_s[12] ? 12'(-diff_s) : diff_s[11:0];
  assign sum        = {1'b0, th_q} + {1'b0, tl_q};
  assign quot       = const_div ? DivNumW'(recip_prod[ProdW-1:RecipShift])
                                : div_rsp_i.quotient;
  assign q_s        = neg_q ? -$signed({2'b00, quot[11:0]}) : $signed({2'b00, quot[11:0]});
  assign fs         = $signed({2'b00, start_q}) + q_s;
  assign len_new    = (quot[DivNumW-1:17] != '0) ? '1 : quot[16:1];
  assign n_sat      = (quot[DivNumW-1:16] != '0) ? '1 : quot[15:0];
  assign t1         = (ticks_q != '0) ? ticks_q - 16'd1 : '0;
  assign nz         = {len_q[3] != '0, len_q[2] != '0, len_q[1] != '0, len_q[0] != '0};
  assign nz_post    = {len_new != '0, nz[2:0]};
  assign sk_next    = seek(nz, {1'b0, pidx_q} + 3'd1);
  assign sk0        = seek(nz, 3'd0);
  assign sk_post    = seek(nz_post, 3'd0);
  assign idx_inc    = index_q + 16'd1;
  assign periods_m1 = periods_q - 16'd1;
  assign fin        = (idx_inc >= total_q);

  always_comb begin
    div_req_o.start    = 1'b0;
    div_req_o.dividend = '0;
    div_req_o.divisor  = '0;
    unique case (op_q)
      OP_TOT: begin
        div_req_o.dividend = DivNumW'(dur_q);
        div_req_o.divisor  = DivDenW'(substep_ms_i);
      end
      OP_Q: begin
        div_req_o.dividend = diff_mag * index_q;
        div_req_o.divisor  = DivDenW'(total_q);
      end
      OP_TH: begin
        div_req_o.dividend = DivNumW'(duty_q) * DivNumW'(10000);
        div_req_o.divisor  = DivDenW'(f_q);
      end
      OP_TL: begin
        div_req_o.dividend = DivNumW'(duty_inv) * DivNumW'(10000);
        div_req_o.divisor  = DivDenW'(f_q);
      end
      OP_N: begin
        div_req_o.dividend = DivNumW'(substep_ms_i) * DivNumW'(1000);
        div_req_o.divisor  = sum;
      end
      OP_U0: begin
        div_req_o.dividend = DivNumW'(th_q) * DivNumW'(ratio_sat);
        div_req_o.divisor  = DivDenW'(7'd100);
      end
      OP_U1: begin
        div_req_o.dividend = DivNumW'(th_q) * DivNumW'(ratio_inv);
        div_req_o.divisor  = DivDenW'(7'd100);
      end
      OP_U2: begin
        div_req_o.dividend = DivNumW'(tl_q) * DivNumW'(ratio_sat);
        div_req_o.divisor  = DivDenW'(7'd100);
      end
      OP_U3: begin
        div_req_o.dividend = DivNumW'(tl_q) * DivNumW'(ratio_inv);
        div_req_o.divisor  = DivDenW'(7'd100);
      end
      default: ;
    endcase
    if (state_q == S_ISSUE) div_req_o.start = !const_div;
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    dur_d      = dur_q;
    duty_d     = duty_q;
    start_d    = start_q;
    end_d      = end_q;
    f_d        = f_q;
    total_d    = total_q;
    index_d    = index_q;
    periods_d  = periods_q;
    pidx_d     = pidx_q;
    ticks_d    = ticks_q;
    len_d      = len_q;
    active_d   = active_q;
    neg_d      = neg_q;
    th_d       = th_q;
    tl_d       = tl_q;
    prod_d     = prod_q;
    res_pat_d  = res_pat_q;
    res_busy_d = res_busy_q;
    res_done_d = res_done_q;
    ov_d       = ov_q && !out_ready_i;
    opat_d     = opat_q;
    obusy_d    = obusy_q;
    odone_d    = odone_q;
    pop_o      = 1'b0;
    empty      = 1'b0;
    end_sub    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          pop_o  = 1'b1;
          dur_d  = item_i.duration;
          duty_d = item_i.duty;
          if (item_i.cmd) begin
            start_d   = item_i.start_freq & FreqMask;
            end_d     = item_i.end_freq & FreqMask;
            index_d   = '0;
            periods_d = '0;
            pidx_d    = '0;
            ticks_d   = '0;
            if (substep_ms_i == '0) begin
              total_d    = '0;
              active_d   = 1'b0;
              res_pat_d  = PatOff;
              res_busy_d = 1'b0;
              res_done_d = 1'b1;
              state_d    = S_OUT;
            end else begin
              op_d    = OP_TOT;
              state_d = S_ISSUE;
            end
          end else if (!active_q) begin
            res_pat_d  = PatOff;
            res_busy_d = 1'b0;
            res_done_d = 1'b0;
            state_d    = S_OUT;
          end else if (periods_q == '0) begin
            op_d    = OP_Q;
            state_d = S_ISSUE;
          end else begin
            state_d = S_TICK;
          end
        end
      end
      S_ISSUE: begin
        neg_d   = diff_s[12];
        prod_d  = div_req_o.dividend;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp_i.done || const_div) begin
          state_d = S_ISSUE;
          unique case (op_q)
            OP_TOT: begin
              total_d    = quot[15:0];
              active_d   = (quot[15:0] != '0);
              res_pat_d  = PatOff;
              res_busy_d = (quot[15:0] != '0);
              res_done_d = (quot[15:0] == '0);
              state_d    = S_OUT;
            end
            OP_Q: begin
              if (fs <= 14'sd0) begin
                empty = 1'b1;
              end else begin
                f_d  = fs[11:0];
                op_d = OP_TH;
              end
            end
            OP_TH: begin
              th_d = quot[19:0];
              op_d = OP_TL;
            end
            OP_TL: begin
              tl_d = quot[19:0];
              if ((th_q == '0) && (quot[19:0] == '0)) empty = 1'b1;
              else op_d = OP_N;
            end
            OP_N: begin
              if (quot == '0) begin
                empty = 1'b1;
              end else begin
                periods_d = n_sat;
                op_d      = OP_U0;
              end
            end
            OP_U0: begin
              len_d[0] = len_new;
              op_d     = OP_U1;
            end
            OP_U1: begin
              len_d[1] = len_new;
              op_d     = OP_U2;
            end
            OP_U2: begin
              len_d[2] = len_new;
              op_d     = OP_U3;
            end
            OP_U3: begin
              len_d[3] = len_new;
              if (!sk_post[2]) begin
                empty = 1'b1;
              end else begin
                pidx_d  = sk_post[1:0];
                ticks_d = (sk_post[1:0] == 2'd3) ? len_new : len_q[sk_post[1:0]];
                state_d = S_TICK;
              end
            end
            default: ;
          endcase
        end
      end
      S_TICK: begin
        res_pat_d  = phase_pattern(pidx_q);
        res_busy_d = 1'b1;
        res_done_d = 1'b0;
        state_d    = S_OUT;
        if (t1 == '0) begin
          if (sk_next[2]) begin
            pidx_d  = sk_next[1:0];
            ticks_d = len_q[sk_next[1:0]];
          end else begin
            periods_d = periods_m1;
            if (periods_m1 == '0) begin
              end_sub = 1'b1;
            end else begin
              pidx_d  = sk0[1:0];
              ticks_d = len_q[sk0[1:0]];
            end
          end
        end else begin
          ticks_d = t1;
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          opat_d  = res_pat_q;
          obusy_d = res_busy_q;
          odone_d = res_done_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (empty) begin
      res_pat_d = PatOff;
      state_d   = S_OUT;
    end
    if (empty || end_sub) begin
      periods_d  = '0;
      index_d    = idx_inc;
      res_busy_d = 1'b1;
      res_done_d = fin;
      if (fin) active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    dur_q      <= dur_d;
    duty_q     <= duty_d;
    f_q        <= f_d;
    neg_q      <= neg_d;
    th_q       <= th_d;
    tl_q       <= tl_d;
    prod_q     <= prod_d;
    res_pat_q  <= res_pat_d;
    res_busy_q <= res_busy_d;
    res_done_q <= res_done_d;
    opat_q     <= opat_d;
    obusy_q    <= obusy_d;
    odone_q    <= odone_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_TOT;
      start_q   <= '0;
      end_q     <= '0;
      total_q   <= '0;
      index_q   <= '0;
      periods_q <= '0;
      pidx_q    <= '0;
      ticks_q   <= '0;
      for (int k = 0; k < 4; k++) len_q[k] <= '0;
      active_q  <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      start_q   <= start_d;
      end_q     <= end_d;
      total_q   <= total_d;
      index_q   <= index_d;
      periods_q <= periods_d;
      pidx_q    <= pidx_d;
      ticks_q   <= ticks_d;
      len_q     <= len_d;
      active_q  <= active_d;
      ov_q      <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_pat_o   = opat_q;
  assign out_busy_o  = obusy_q;
  assign out_done_o  = odone_q;

  `ASSERT_IMPLIES(a_active_total, clk_i, rst_ni, active_q, total_q != '0)
  `ASSERT_IMPLIES(a_tick_live, clk_i, rst_ni, state_q == S_TICK, active_q && periods_q != '0)
  `ASSERT_IMPLIES(a_div_free, clk_i, rst_ni, div_req_o.start, !div_rsp_i.busy)
  `ASSERT_NEXT(a_issue_runs, clk_i, rst_ni, state_q == S_ISSUE && !const_div, div_rsp_i.busy)

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for swept_tone_bridge_pulse_generator_core.
// Depends on stbpg_pkg; a scoreboard class predicts the drive stream per input transfer.
// Directed loads and ticks come first, then random sweeps under several register settings.
module tb_top;
  import stbpg_pkg::*;

  localparam int CycleLimit = 4000000;
  localparam int Drain = 400;

  typedef struct {
    logic [PatW-1:0] pattern;
    logic busy;
    logic done;
  } drive_t;

  class drive_scoreboard;
    int unsigned ratio, step_ms;
    int unsigned ph_idx, ticks_left, periods, sub_idx, sub_total;
    int unsigned ph_len[4];
    int unsigned sw_start, sw_end;
    bit running;
    drive_t pending[$];
    int errors, loads, ticks, segments_ended, results;

    function new();
      ratio = RatioReset;
      step_ms = SubstepReset;
      running = 0;
      ph_idx = 0; ticks_left = 0; periods = 0; sub_idx = 0; sub_total = 0;
      sw_start = 0; sw_end = 0;
      for (int j = 0; j < 4; j++) ph_len[j] = 0;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    function bit find_phase(int unsigned from);
      for (int unsigned j = from; j < 4; j++) begin
        if (ph_len[j] != 0) begin
          ph_idx = j;
          ticks_left = ph_len[j];
          return 1;
        end
      end
      return 0;
    endfunction

    function void close_substep(ref bit done);
      periods = 0;
      sub_idx++;
      if (sub_idx >= sub_total) begin
        running = 0;
        done = 1;
      end
    endfunction

    function int unsigned to_ticks(longint unsigned us);
      longint unsigned t;
      t = us >> 1;
      return (t > 65535) ? 65535 : int'(t);
    endfunction

    function bit open_substep(logic [PctW-1:0] duty_in);
      longint d, r, diff, q, fs, th, tl, total, n;
      longint unsigned us[4];
      bit any;
      d = (duty_in > 100) ? 100 : duty_in;
      r = (ratio > 100) ? 100 : ratio;
      any = 0;
      if (sub_total == 0) return 0;
      diff = longint'(sw_end) - longint'(sw_start);
      q = (diff * longint'(sub_idx)) / longint'(sub_total);
      fs = longint'(sw_start) + q;
      if (fs <= 0) return 0;
      th = (10000 * d) / fs;
      tl = (10000 * (100 - d)) / fs;
      total = th + tl;
      if (total == 0) return 0;
      n = (longint'(step_ms) * 1000) / total;
      if (n == 0) return 0;
      if (n > 65535) n = 65535;
      us[0] = th * r / 100;
      us[1] = th * (100 - r) / 100;
      us[2] = tl * r / 100;
      us[3] = tl * (100 - r) / 100;
      for (int j = 0; j < 4; j++) begin
        ph_len[j] = to_ticks(us[j]);
        if (ph_len[j] != 0) any = 1;
      end
      if (!any) return 0;
      periods = int'(n);
      void'(find_phase(0));
      return 1;
    endfunction

    function void note_input(logic cmd, logic [FreqW-1:0] sf, logic [FreqW-1:0] ef,
                             logic [DurW-1:0] dur, logic [PctW-1:0] duty);
      drive_t e;
      bit done;
      e.pattern = PatOff;
      e.busy = 0;
      done = 0;
      if (cmd) begin
        loads++;
        sw_start = sf;
        sw_end = ef;
        sub_total = (step_ms == 0) ? 0 : dur / step_ms;
        sub_idx = 0; periods = 0; ph_idx = 0; ticks_left = 0;
        running = (sub_total != 0);
        e.busy = running;
        done = !running;
      end else begin
        ticks++;
        if (running) begin
          e.busy = 1;
          if (periods == 0 && !open_substep(duty)) begin
            close_substep(done);
          end else begin
            case (ph_idx)
              0: e.pattern = PatHighOn;
              2: e.pattern = PatLowOn;
              default: e.pattern = PatOff;
            endcase
            if (ticks_left != 0) ticks_left--;
            if (ticks_left == 0 && !find_phase(ph_idx + 1)) begin
              periods--;
              if (periods == 0) close_substep(done);
              else void'(find_phase(0));
            end
          end
        end
      end
      e.done = done;
      if (done) segments_ended++;
      pending.push_back(e);
    endfunction

    task check_result(logic [7:0] data, logic busy, logic last);
      drive_t e;
      results++;
      if (pending.size() == 0) begin
        report("result transfer with no expectation waiting");
        return;
      end
      e = pending.pop_front();
      if (data !== {4'h0, e.pattern})
        report($sformatf("drive_pattern %0h, expected %0h", data, e.pattern));
      if (busy !== e.busy)
        report($sformatf("busy %b, expected %b", busy, e.busy));
      if (last !== e.done)
        report($sformatf("segment end %b, expected %b", last, e.done));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [7:0] cfg_data_i = '0;

  drive_scoreboard sb = new();
  bit steady = 0;
  int hold_off = 0;
  int cycles = 0;
  int sent = 0;

  swept_tone_bridge_pulse_generator_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
        hold_off <= hold_off - 1;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 35);
      end
    end
  end

  task send_item(logic cmd, logic [FreqW-1:0] sf, logic [FreqW-1:0] ef,
                 logic [DurW-1:0] dur, logic [PctW-1:0] duty);
    if (!steady && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {1'b0, duty, dur, ef, sf};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, sf, ef, dur, duty);
    sent++;
  endtask

  task send_tick(logic [PctW-1:0] duty);
    send_item(1'b0, FreqW'($urandom), FreqW'($urandom), DurW'($urandom), duty);
  endtask

  task write_reg(logic idx, logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgRatio) sb.ratio = value & 8'h7f;
    else sb.step_ms = value;
  endtask

  function logic [FreqW-1:0] pick_freq();
    if ($urandom_range(9) < 6) return FreqW'($urandom_range(2000, 4095));
    return FreqW'($urandom);
  endfunction

  task random_sweep();
    int k, run;
    k = $urandom_range(0, 4);
    send_item(1'b1, pick_freq(), pick_freq(),
              ($urandom_range(9) == 0) ? 16'($urandom) : 16'(sb.step_ms * k),
              PctW'($urandom));
    run = ($urandom_range(9) == 0) ? $urandom_range(100, 600) : $urandom_range(1, 40);
    for (int i = 0; i < run; i++) begin
      if ($urandom_range(49) == 0)
        send_item(1'b1, FreqW'($urandom), FreqW'($urandom), DurW'($urandom),
                  PctW'($urandom));
      else send_tick(($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100)));
    end
  endtask

  initial begin
    logic [7:0] ratios[6];
    logic [7:0] steps[6];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(1'b1, 12'd100, 12'd200, 16'd5, 7'd50);
    write_reg(CfgSubstep, 8'd1);
    send_item(1'b1, 12'd4095, 12'd4095, 16'd0, 7'd50);
    send_tick(7'd50);
    send_item(1'b1, 12'd4095, 12'd1, 16'd3, 7'd0);
    send_tick(7'd0);
    send_tick(7'd127);
    for (int i = 0; i < 4; i++) send_tick(7'd50);
    send_item(1'b1, 12'd1, 12'd4095, 16'd65535, 7'd100);
    for (int i = 0; i < 3; i++) send_tick(7'd100);
    send_item(1'b1, 12'd0, 12'd0, 16'd2, 7'd50);
    send_tick(7'd50);
    send_tick(7'd50);
    send_item(1'b1, 12'd4095, 12'd4095, 16'd1, 7'd100);
    for (int i = 0; i < 6; i++) send_tick(7'd100);

    ratios = '{8'd0, 8'd100, 8'd127, 8'd50, 8'd85, 8'd0};
    steps = '{8'd1, 8'd2, 8'd255, 8'd1, 8'd0, 8'd3};
    for (int p = 0; p < 6; p++) begin
      write_reg(CfgRatio, ratios[p]);
      write_reg(CfgSubstep, steps[p]);
      steady = (p == 3);
      if (p == 1) hold_off = 400;
      while (sent < 30 + (p + 1) * 290) random_sweep();
    end
    steady = 0;
    write_reg(CfgRatio, 8'($urandom_range(0, 127)));
    write_reg(CfgSubstep, 8'($urandom_range(1, 4)));
    while (sent < 1780) random_sweep();

    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    $display("covered %0d loads and %0d ticks, %0d segment ends, %0d results checked",
             sb.loads, sb.ticks, sb.segments_ended, sb.results);
    $display("register settings swept ratio 0..127 and sub-step 0..255 ms");
    if (sb.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule

>>> files.f
+incdir+design
design/stbpg_pkg.sv
design/stbpg_front.sv
design/stbpg_div.sv
design/stbpg_seq.sv
design/swept_tone_bridge_pulse_generator_core.sv
tb/sv/tb_top.sv
